/* rtl/core/lssfs_pkg.sv */
`default_nettype none

package lssfs_pkg;

  // Scan phase codes
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhIdent  = 3'd1;
  localparam logic [2:0] PhProbe  = 3'd2;
  localparam logic [2:0] PhCheck  = 3'd3;
  localparam logic [2:0] PhAssign = 3'd4;
  localparam logic [2:0] PhStore  = 3'd5;

  typedef enum logic [1:0] {
    ActStart   = 2'd0,
    ActRxFrame = 2'd1,
    ActTimeout = 2'd2,
    ActNone    = 2'd3
  } action_e;

  localparam int unsigned WinCntWidth = 7;

  localparam logic [10:0] SlaveIdent   = 11'h7E4;
  localparam logic [7:0]  CsIdentify   = 8'h81;
  localparam logic [7:0]  CsIdentResp  = 8'h4F;
  localparam logic [7:0]  CsAssign     = 8'h11;
  localparam logic [7:0]  CsStore      = 8'h17;
  localparam logic [7:0]  CsSwitchWait = 8'h04;
  localparam logic [7:0]  IdentBitChk  = 8'h80;
  localparam logic [2:0]  NumParts     = 3'd4;

  // Fastscan probe frame: cs, id bits LE, bit check, sub, next
  function automatic logic [63:0] scan_frame(input logic [31:0] bits,
                                             input logic [4:0]  bitchk,
                                             input logic [1:0]  sub,
                                             input logic [1:0]  nxt);
    scan_frame = {6'd0, nxt, 6'd0, sub, 3'd0, bitchk, bits, CsIdentify};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lss_fastscan_master.sv */
// LSS fastscan master, event driven.
// The result beat of an event is registered and shown in the cycle after the event beat is accepted.
// Throughput: one event beat per cycle while out_ready_i takes each result beat; else in_ready_o stalls.
// Reset (rst_ni low, asynchronous): scan idle, bit position 31, all counters
// and flags cleared, no result pending.
`default_nettype none

module lss_fastscan_master import lssfs_pkg::*; #(
  parameter int unsigned MAX_WINDOW_FRAMES = 127
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  new_node_id_i,
  input  wire logic [10:0] rx_ident_i,
  input  wire logic [7:0]  rx_first_byte_i,
  input  wire logic [7:0]  rx_second_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        tx_valid_o,
  output      logic [63:0] tx_payload_o,
  output      logic        part_valid_o,
  output      logic [1:0]  part_index_o,
  output      logic [31:0] part_value_o,
  output      logic        done_res_o,
  output      logic        success_o
);

  localparam logic [WinCntWidth-1:0] MaxWin = WinCntWidth'(MAX_WINDOW_FRAMES);

  logic [2:0]             phase_q, phase_d;
  logic [31:0]            part_bits_q, part_bits_d;
  logic [4:0]             bit_pos_q, bit_pos_d;
  logic [2:0]             part_num_q, part_num_d;
  logic [1:0]             sub_idx_q, sub_idx_d;
  logic [1:0]             next_idx_q, next_idx_d;
  logic [7:0]             target_q, target_d;
  logic                   heard_q, heard_d;
  logic                   matched_q, matched_d;
  logic [WinCntWidth-1:0] win_cnt_q, win_cnt_d;

  logic        out_valid_q;
  logic        tx_valid_q, tx_valid_d;
  logic [63:0] tx_payload_q, tx_payload_d;
  logic        part_valid_q, part_valid_d;
  logic [1:0]  part_index_q, part_index_d;
  logic [31:0] part_value_q, part_value_d;
  logic        done_q, done_d;
  logic        success_q, success_d;

  logic in_fire;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic        listening;
    logic        do_close;
    logic [2:0]  pn_inc;
    action_e     act;
    phase_d      = phase_q;
    part_bits_d  = part_bits_q;
    bit_pos_d    = bit_pos_q;
    part_num_d   = part_num_q;
    sub_idx_d    = sub_idx_q;
    next_idx_d   = next_idx_q;
    target_d     = target_q;
    heard_d      = heard_q;
    matched_d    = matched_q;
    win_cnt_d    = win_cnt_q;
    tx_valid_d   = 1'b0;
    tx_payload_d = '0;
    part_valid_d = 1'b0;
    part_index_d = '0;
    part_value_d = '0;
    done_d       = 1'b0;
    success_d    = 1'b0;
    do_close     = 1'b0;
    pn_inc       = part_num_q + 3'd1;
    act          = action_e'(action_i);
    listening    = (phase_q == PhIdent) || (phase_q == PhProbe) || (phase_q == PhCheck);

    case (act)
      ActStart: begin
        part_bits_d  = '0;
        bit_pos_d    = 5'd31;
        part_num_d   = '0;
        sub_idx_d    = '0;
        next_idx_d   = '0;
        target_d     = new_node_id_i;
        heard_d      = 1'b0;
        matched_d    = 1'b0;
        win_cnt_d    = '0;
        tx_valid_d   = 1'b1;
        tx_payload_d = {16'd0, IdentBitChk, 32'd0, CsIdentify};
        phase_d      = PhIdent;
      end
      ActRxFrame: begin
        if (listening) begin
          heard_d = 1'b1;
          if (phase_q == PhIdent) begin
            matched_d = (rx_ident_i == SlaveIdent) && (rx_first_byte_i == CsIdentResp);
          end
          win_cnt_d = win_cnt_q + WinCntWidth'(1);
          do_close  = (win_cnt_d >= MaxWin);
        end else if (phase_q == PhAssign) begin
          if (rx_first_byte_i == CsAssign && rx_second_byte_i == 8'd0) begin
            tx_valid_d   = 1'b1;
            tx_payload_d = {56'd0, CsStore};
            phase_d      = PhStore;
          end else begin
            done_d  = 1'b1;
            phase_d = PhIdle;
          end
        end else if (phase_q == PhStore) begin
          done_d  = 1'b1;
          phase_d = PhIdle;
          if (rx_first_byte_i == CsStore && rx_second_byte_i == 8'd0) begin
            tx_valid_d   = 1'b1;
            tx_payload_d = {56'd0, CsSwitchWait};
            success_d    = 1'b1;
          end
        end
      end
      ActTimeout: begin
        if (listening) begin
          do_close = 1'b1;
        end else if (phase_q == PhAssign || phase_q == PhStore) begin
          done_d  = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: ;
    endcase

    // End of a listen window; uses the values updated by this beat
    if (do_close) begin
      if (phase_q == PhIdent) begin
        if (heard_d && matched_d) begin
          part_bits_d  = '0;
          bit_pos_d    = 5'd31;
          part_num_d   = '0;
          sub_idx_d    = '0;
          next_idx_d   = '0;
          heard_d      = 1'b0;
          matched_d    = 1'b0;
          win_cnt_d    = '0;
          tx_valid_d   = 1'b1;
          tx_payload_d = scan_frame('0, 5'd31, 2'd0, 2'd0);
          phase_d      = PhProbe;
        end else begin
          done_d  = 1'b1;
          phase_d = PhIdle;
        end
      end else if (phase_q == PhProbe) begin
        // silence means the probed bit is 1
        if (!heard_d) begin
          part_bits_d = part_bits_q | (32'd1 << bit_pos_q);
        end
        heard_d    = 1'b0;
        matched_d  = 1'b0;
        win_cnt_d  = '0;
        tx_valid_d = 1'b1;
        if (bit_pos_q == 5'd0) begin
          next_idx_d   = next_idx_q + 2'd1;
          tx_payload_d = scan_frame(part_bits_d, 5'd0, sub_idx_q, next_idx_d);
          phase_d      = PhCheck;
        end else begin
          bit_pos_d    = bit_pos_q - 5'd1;
          tx_payload_d = scan_frame(part_bits_d, bit_pos_d, sub_idx_q, next_idx_q);
        end
      end else begin
        part_valid_d = 1'b1;
        part_index_d = part_num_q[1:0];
        part_value_d = part_bits_q;
        sub_idx_d    = sub_idx_q + 2'd1;
        part_num_d   = pn_inc;
        tx_valid_d   = 1'b1;
        if (pn_inc >= NumParts) begin
          tx_payload_d = {48'd0, target_q, CsAssign};
          phase_d      = PhAssign;
        end else begin
          part_bits_d  = '0;
          bit_pos_d    = 5'd31;
          heard_d      = 1'b0;
          matched_d    = 1'b0;
          win_cnt_d    = '0;
          tx_payload_d = scan_frame('0, 5'd31, sub_idx_d, next_idx_q);
          phase_d      = PhProbe;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      part_bits_q <= '0;
      bit_pos_q   <= 5'd31;
      part_num_q  <= '0;
      sub_idx_q   <= '0;
      next_idx_q  <= '0;
      target_q    <= '0;
      heard_q     <= 1'b0;
      matched_q   <= 1'b0;
      win_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        part_bits_q <= part_bits_d;
        bit_pos_q   <= bit_pos_d;
        part_num_q  <= part_num_d;
        sub_idx_q   <= sub_idx_d;
        next_idx_q  <= next_idx_d;
        target_q    <= target_d;
        heard_q     <= heard_d;
        matched_q   <= matched_d;
        win_cnt_q   <= win_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload, loaded with each accepted event
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tx_valid_q   <= tx_valid_d;
      tx_payload_q <= tx_payload_d;
      part_valid_q <= part_valid_d;
      part_index_q <= part_index_d;
      part_value_q <= part_value_d;
      done_q       <= done_d;
      success_q    <= success_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = tx_valid_q;
  assign tx_payload_o = tx_payload_q;
  assign part_valid_o = part_valid_q;
  assign part_index_o = part_index_q;
  assign part_value_o = part_value_q;
  assign done_res_o   = done_q;
  assign success_o    = success_q;

endmodule

`default_nettype wire

/* sim/lss_fastscan_master_tb.sv */
`timescale 1ns / 100ps

module lss_fastscan_master_tb;
  import lssfs_pkg::*;

  localparam int unsigned WindowLimit = 127;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBeats = 450;

  typedef struct packed {
    logic        tx_valid;
    logic [63:0] tx_payload;
    logic        part_valid;
    logic [1:0]  part_index;
    logic [31:0] part_value;
    logic        done_res;
    logic        success;
  } reply_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i         = ActNone;
  logic [7:0]  new_node_id_i    = 8'd0;
  logic [10:0] rx_ident_i       = 11'd0;
  logic [7:0]  rx_first_byte_i  = 8'd0;
  logic [7:0]  rx_second_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b1;
  logic        tx_valid_o;
  logic [63:0] tx_payload_o;
  logic        part_valid_o;
  logic [1:0]  part_index_o;
  logic [31:0] part_value_o;
  logic        done_res_o;
  logic        success_o;

  bit          in_idles  = 1'b0;
  bit          out_idles = 1'b0;
  int unsigned errors     = 0;
  int unsigned sent_beats = 0;
  int unsigned cycle_cnt  = 0;
  reply_t      expected_replies[$];

  // predicted scan state
  logic [2:0]  scan_phase;
  logic [31:0] scan_bits;
  logic [4:0]  scan_bitpos;
  logic [2:0]  scan_part;
  logic [1:0]  scan_sub;
  logic [1:0]  scan_next;
  logic [7:0]  scan_node;
  logic        win_heard;
  logic        win_matched;
  logic [6:0]  win_frames;

  lss_fastscan_master #(
    .MAX_WINDOW_FRAMES(WindowLimit)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .new_node_id_i   (new_node_id_i),
    .rx_ident_i      (rx_ident_i),
    .rx_first_byte_i (rx_first_byte_i),
    .rx_second_byte_i(rx_second_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_valid_o      (tx_valid_o),
    .tx_payload_o    (tx_payload_o),
    .part_valid_o    (part_valid_o),
    .part_index_o    (part_index_o),
    .part_value_o    (part_value_o),
    .done_res_o      (done_res_o),
    .success_o       (success_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] probe_frame(input logic [7:0] bitchk);
    return {6'd0, scan_next, 6'd0, scan_sub, bitchk, scan_bits, CsIdentify};
  endfunction

  task automatic reset_scan();
    scan_phase  = PhIdle;
    scan_bits   = '0;
    scan_bitpos = 5'd31;
    scan_part   = '0;
    scan_sub    = '0;
    scan_next   = '0;
    scan_node   = '0;
    win_heard   = 1'b0;
    win_matched = 1'b0;
    win_frames  = '0;
  endtask

  task automatic clear_window();
    win_heard   = 1'b0;
    win_matched = 1'b0;
    win_frames  = '0;
  endtask

  task automatic emit_frame(inout reply_t r, input logic [63:0] payload);
    r.tx_valid   = 1'b1;
    r.tx_payload = payload;
  endtask

  task automatic end_scan(inout reply_t r, input logic ok);
    r.done_res = 1'b1;
    r.success  = ok;
    scan_phase = PhIdle;
  endtask

  task automatic close_listen(inout reply_t r);
    if (scan_phase == PhIdent) begin
      if (win_heard && win_matched) begin
        scan_bits   = '0;
        scan_bitpos = 5'd31;
        scan_part   = '0;
        scan_sub    = '0;
        scan_next   = '0;
        clear_window();
        emit_frame(r, probe_frame({3'd0, scan_bitpos}));
        scan_phase = PhProbe;
      end else begin
        end_scan(r, 1'b0);
      end
    end else if (scan_phase == PhProbe) begin
      // silence on a probe means the probed bit is set
      if (!win_heard) scan_bits[scan_bitpos] = 1'b1;
      clear_window();
      if (scan_bitpos == 5'd0) begin
        scan_next = scan_next + 2'd1;
        emit_frame(r, probe_frame(8'd0));
        scan_phase = PhCheck;
      end else begin
        scan_bitpos = scan_bitpos - 5'd1;
        emit_frame(r, probe_frame({3'd0, scan_bitpos}));
      end
    end else begin
      r.part_valid = 1'b1;
      r.part_index = scan_part[1:0];
      r.part_value = scan_bits;
      scan_sub  = scan_sub + 2'd1;
      scan_part = scan_part + 3'd1;
      if (scan_part >= NumParts) begin
        emit_frame(r, {48'd0, scan_node, CsAssign});
        scan_phase = PhAssign;
      end else begin
        scan_bits   = '0;
        scan_bitpos = 5'd31;
        clear_window();
        emit_frame(r, probe_frame(8'd31));
        scan_phase = PhProbe;
      end
    end
  endtask

  task automatic predict_reply(input logic [1:0] act, input logic [7:0] nid,
                               input logic [10:0] ident, input logic [7:0] b0,
                               input logic [7:0] b1, output reply_t r);
    logic listening;
    r = '0;
    listening = (scan_phase == PhIdent) || (scan_phase == PhProbe) ||
                (scan_phase == PhCheck);
    case (act)
      ActStart: begin
        reset_scan();
        scan_node = nid;
        emit_frame(r, {16'd0, IdentBitChk, 32'd0, CsIdentify});
        scan_phase = PhIdent;
      end
      ActRxFrame: begin
        if (listening) begin
          win_heard = 1'b1;
          if (scan_phase == PhIdent)
            win_matched = (ident == SlaveIdent) && (b0 == CsIdentResp);
          win_frames = win_frames + 7'd1;
          if (win_frames >= 7'(WindowLimit)) close_listen(r);
        end else if (scan_phase == PhAssign) begin
          if (b0 == CsAssign && b1 == 8'd0) begin
            emit_frame(r, 64'(CsStore));
            scan_phase = PhStore;
          end else begin
            end_scan(r, 1'b0);
          end
        end else if (scan_phase == PhStore) begin
          if (b0 == CsStore && b1 == 8'd0) begin
            emit_frame(r, 64'(CsSwitchWait));
            end_scan(r, 1'b1);
          end else begin
            end_scan(r, 1'b0);
          end
        end
      end
      ActTimeout: begin
        if (listening) close_listen(r);
        else if (scan_phase == PhAssign || scan_phase == PhStore) end_scan(r, 1'b0);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    reply_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {tx_valid_o, tx_payload_o, part_valid_o, part_index_o, part_value_o,
             done_res_o, success_o};
      if (expected_replies.size() == 0) begin
        $display("%0t: reply beat with nothing expected, got %0h", $time, got);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
        compare_field("tx_payload", want.tx_payload, got.tx_payload);
        compare_field("part_valid", 64'(want.part_valid), 64'(got.part_valid));
        compare_field("part_index", 64'(want.part_index), 64'(got.part_index));
        compare_field("part_value", 64'(want.part_value), 64'(got.part_value));
        compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
        compare_field("success", 64'(want.success), 64'(got.success));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_reply(action_i, new_node_id_i, rx_ident_i, rx_first_byte_i,
                    rx_second_byte_i, want);
      expected_replies.push_back(want);
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    int unsigned stall_cnt;
    if (stall_cnt > 0) stall_cnt = stall_cnt - 1;
    else if (out_idles && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 12);
    out_ready_i <= (stall_cnt == 0);
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("lss_fastscan_master test failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [10:0] rand_ident();
    return 11'($urandom_range(0, 2047));
  endfunction

  // called at a rising edge; valid stays up across back-to-back beats
  task automatic send_event(input logic [1:0] act, input logic [7:0] nid,
                            input logic [10:0] ident, input logic [7:0] b0,
                            input logic [7:0] b1);
    if (in_idles && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    new_node_id_i    <= nid;
    rx_ident_i       <= ident;
    rx_first_byte_i  <= b0;
    rx_second_byte_i <= b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_beats++;
  endtask

  task automatic send_start(input logic [7:0] nid);
    send_event(ActStart, nid, rand_ident(), rand_byte(), rand_byte());
  endtask

  task automatic send_frame(input logic [10:0] ident, input logic [7:0] b0,
                            input logic [7:0] b1);
    send_event(ActRxFrame, rand_byte(), ident, b0, b1);
  endtask

  task automatic send_timeout();
    send_event(ActTimeout, rand_byte(), rand_ident(), rand_byte(), rand_byte());
  endtask

  task automatic send_no_action();
    send_event(ActNone, rand_byte(), rand_ident(), rand_byte(), rand_byte());
  endtask

  task automatic test_idle_events();
    send_frame(11'h7FF, 8'hFF, 8'hFF);
    send_frame(11'h000, 8'h00, 8'h00);
    send_timeout();
    send_event(ActNone, 8'hFF, 11'h7FF, 8'hFF, 8'hFF);
    send_event(ActNone, 8'h00, 11'h000, 8'h00, 8'h00);
  endtask

  task automatic test_identify();
    // nobody answers
    send_start(8'h00);
    send_timeout();
    // right identifier, wrong command byte
    send_start(8'hFF);
    send_frame(SlaveIdent, 8'h4E, 8'h00);
    send_timeout();
    // good answer followed by a foreign frame: last frame decides
    send_start(8'h5A);
    send_frame(SlaveIdent, CsIdentResp, 8'h00);
    send_frame(11'h7E5, CsIdentResp, 8'h00);
    send_timeout();
    // foreign frame then good answer: scan proceeds
    send_start(8'hA5);
    send_frame(11'h123, 8'h00, 8'hFF);
    send_frame(SlaveIdent, CsIdentResp, 8'hFF);
    send_timeout();
    send_no_action();
    send_frame(rand_ident(), rand_byte(), rand_byte());
    send_timeout();
    send_timeout();
    // restart while busy drops the running scan
    send_start(8'h01);
    send_timeout();
    send_timeout();
  endtask

  task automatic test_window_limit();
    send_start(8'h42);
    // the last of these closes the identify window by count
    repeat (WindowLimit) send_frame(SlaveIdent, CsIdentResp, rand_byte());
    send_timeout();
    send_start(8'h00);
    send_timeout();
  endtask

  // one well-formed scan against a simulated slave, broken now and then
  task automatic run_scan();
    logic [31:0] identity [4];
    logic [7:0]  node;
    logic [7:0]  bad_b0;
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 7))
        0:       identity[p] = 32'h0000_0000;
        1:       identity[p] = 32'hFFFF_FFFF;
        default: identity[p] = $urandom();
      endcase
    end
    case ($urandom_range(0, 5))
      0:       node = 8'h00;
      1:       node = 8'hFF;
      default: node = rand_byte();
    endcase
    send_start(node);
    repeat ($urandom_range(0, 2)) send_frame(rand_ident(), rand_byte(), rand_byte());
    if ($urandom_range(0, 9) == 0) begin
      send_timeout();
      return;
    end
    send_frame(SlaveIdent, CsIdentResp, rand_byte());
    send_timeout();

    for (int p = 0; p < 4; p++) begin
      // bit index -1 stands for the final check window
      for (int b = 31; b >= -1; b--) begin
        if ($urandom_range(0, 599) == 0) begin
          send_start(rand_byte());
          return;
        end
        if ($urandom_range(0, 49) == 0) send_no_action();
        if (b >= 0) begin
          if (identity[p][b] == 1'b0)
            repeat ($urandom_range(1, 2)) send_frame(rand_ident(), rand_byte(), rand_byte());
        end else if ($urandom_range(0, 1) == 0) begin
          send_frame(SlaveIdent, rand_byte(), rand_byte());
        end
        send_timeout();
      end
    end

    bad_b0 = rand_byte();
    if (bad_b0 == CsAssign) bad_b0 = ~bad_b0;
    case ($urandom_range(0, 9))
      0: begin
        send_timeout();
        return;
      end
      1: begin
        send_frame(rand_ident(), CsAssign, 8'($urandom_range(1, 255)));
        return;
      end
      2: begin
        send_frame(rand_ident(), bad_b0, 8'h00);
        return;
      end
      3: begin
        send_start(rand_byte());
        return;
      end
      default: send_frame(rand_ident(), CsAssign, 8'h00);
    endcase

    bad_b0 = rand_byte();
    if (bad_b0 == CsStore) bad_b0 = ~bad_b0;
    case ($urandom_range(0, 9))
      0:       send_timeout();
      1:       send_frame(rand_ident(), CsStore, 8'($urandom_range(1, 255)));
      2:       send_frame(rand_ident(), bad_b0, 8'h00);
      default: send_frame(rand_ident(), CsStore, 8'h00);
    endcase
    if ($urandom_range(0, 2) == 0) send_timeout();
  endtask

  task automatic test_random_scans();
    int unsigned first_beat;
    first_beat = sent_beats;
    while (sent_beats < first_beat + RandomBeats) begin
      in_idles  = ($urandom_range(0, 3) != 0);
      out_idles = ($urandom_range(0, 3) != 0);
      run_scan();
    end
  endtask

  task automatic test_quiet_tail();
    in_idles  = 1'b0;
    out_idles = 1'b0;
    run_scan();
  endtask

  initial begin
    reset_scan();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    in_idles  = 1'b1;
    out_idles = 1'b1;
    test_idle_events();
    test_identify();
    test_window_limit();
    test_random_scans();
    test_quiet_tail();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("lss_fastscan_master test passed");
    end else begin
      $display("lss_fastscan_master test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lssfs_pkg.sv
rtl/core/lss_fastscan_master.sv
sim/lss_fastscan_master_tb.sv
